// ----- rtl/bdpa_pkg.sv -----
package bdpa_pkg;

  // Old image store geometry (power of two)
  localparam int unsigned OLD_DEPTH = 65536;
  localparam int unsigned OLD_AW    = $clog2(OLD_DEPTH);

  localparam int unsigned POS_W      = 48;
  localparam int unsigned OLD_SIZE_W = 17;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CTRL  = 2'd1,
    OP_DIFF  = 2'd2,
    OP_EXTRA = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_ADD  = 2'd1,
    PH_COPY = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_ADD_OVER  = 3'd1,
    ERR_COPY_OVER = 3'd2,
    ERR_NEG_LEN   = 3'd3,
    ERR_ORDER     = 3'd4
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OLD_SIZE = 1'd0,
    CFG_NEW_SIZE = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [15:0]        old_address;
    logic [7:0]         old_byte;
    logic [LEN_W-1:0]   add_length;
    logic [LEN_W-1:0]   copy_length;
    logic [LEN_W-1:0]   seek_offset;
    logic [7:0]         data_byte;
  } item_t;

  // One result on its way to the output stage
  typedef struct packed {
    logic        valid;
    logic        use_old;
    logic [7:0]  data;
    logic [31:0] offset;
    logic        done;
    err_t        err;
  } res_t;

endpackage

// ----- rtl/bdpa_if.sv -----
interface bdpa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [15:0]        old_address;
  logic [7:0]         old_byte;
  logic signed [31:0] add_length;
  logic signed [31:0] copy_length;
  logic signed [31:0] seek_offset;
  logic [7:0]         data_byte;

  modport source (
    output valid, opcode, old_address, old_byte, add_length, copy_length,
           seek_offset, data_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, old_address, old_byte, add_length, copy_length,
           seek_offset, data_byte,
    output ready
  );
endinterface

interface bdpa_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  new_byte;
  logic [31:0] new_offset;
  logic        image_done;
  logic [2:0]  error_code;

  modport source (
    output valid, new_byte, new_offset, image_done, error_code,
    input  ready
  );
  modport sink (
    input  valid, new_byte, new_offset, image_done, error_code,
    output ready
  );
endinterface

// ----- rtl/bdpa_old_ram.sv -----
module bdpa_old_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bdpa_ctrl.sv -----
module bdpa_ctrl import bdpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  item_t                 item,
  input  logic [OLD_SIZE_W-1:0] old_size,
  input  logic [31:0]           new_size,
  output res_t                  res,
  output logic [OLD_AW-1:0]     rd_addr
);

  logic [31:0]      new_pos_r, new_pos_nxt;
  logic [POS_W-1:0] old_pos_r, old_pos_nxt;
  logic [31:0]      add_rem_r, add_rem_nxt;
  logic [31:0]      copy_rem_r, copy_rem_nxt;
  logic [31:0]      seek_r, seek_nxt;
  phase_t           phase_r, phase_nxt;
  logic             err_r, err_nxt;

  logic             fail;
  err_t             fail_code;
  logic             seek_now;
  logic             pos_inc;
  logic [31:0]      seek_sel;
  logic [POS_W-1:0] seek_ext;
  logic [32:0]      add_end;
  logic [33:0]      copy_end;
  logic             in_range;
  logic             last_byte;

  assign add_end   = {1'b0, new_pos_r} + {1'b0, item.add_length};
  assign copy_end  = {1'b0, add_end} + {2'b0, item.copy_length};
  assign last_byte = ({1'b0, new_pos_r} + 33'd1) == {1'b0, new_size};
  assign in_range  = !old_pos_r[POS_W-1]
                     && (old_pos_r < {{(POS_W-OLD_SIZE_W){1'b0}}, old_size})
                     && ((old_pos_r >> OLD_AW) == '0);
  assign rd_addr   = old_pos_r[OLD_AW-1:0];

  always_comb begin
    new_pos_nxt  = new_pos_r;
    add_rem_nxt  = add_rem_r;
    copy_rem_nxt = copy_rem_r;
    seek_nxt     = seek_r;
    phase_nxt    = phase_r;
    err_nxt      = err_r;
    fail         = 1'b0;
    fail_code    = ERR_OK;
    seek_now     = 1'b0;
    pos_inc      = 1'b0;
    seek_sel     = seek_r;
    res          = '0;
    res.err      = ERR_OK;

    case (item.opcode)
      OP_LOAD: begin
      end
      OP_CTRL: begin
        if (!err_r) begin
          if (phase_r != PH_CTRL || new_pos_r >= new_size) begin
            fail      = 1'b1;
            fail_code = ERR_ORDER;
          end else if (item.add_length[31] || item.copy_length[31]) begin
            fail      = 1'b1;
            fail_code = ERR_NEG_LEN;
          end else if (add_end > {1'b0, new_size}) begin
            fail      = 1'b1;
            fail_code = ERR_ADD_OVER;
          end else if (copy_end > {2'b0, new_size}) begin
            fail      = 1'b1;
            fail_code = ERR_COPY_OVER;
          end else begin
            add_rem_nxt  = item.add_length;
            copy_rem_nxt = item.copy_length;
            seek_nxt     = item.seek_offset;
            seek_sel     = item.seek_offset;
            if (item.add_length != '0) begin
              phase_nxt = PH_ADD;
            end else if (item.copy_length != '0) begin
              phase_nxt = PH_COPY;
            end else begin
              seek_now  = 1'b1;
              phase_nxt = PH_CTRL;
            end
          end
        end
      end
      OP_DIFF: begin
        if (!err_r) begin
          if (phase_r != PH_ADD) begin
            fail      = 1'b1;
            fail_code = ERR_ORDER;
          end else begin
            res.valid   = 1'b1;
            res.use_old = in_range;
            res.data    = item.data_byte;
            res.offset  = new_pos_r;
            res.done    = last_byte;
            new_pos_nxt = new_pos_r + 32'd1;
            add_rem_nxt = add_rem_r - 32'd1;
            pos_inc     = 1'b1;
            if (add_rem_r == 32'd1) begin
              if (copy_rem_r != '0) begin
                phase_nxt = PH_COPY;
              end else begin
                seek_now  = 1'b1;
                phase_nxt = PH_CTRL;
              end
            end
          end
        end
      end
      OP_EXTRA: begin
        if (!err_r) begin
          if (phase_r != PH_COPY) begin
            fail      = 1'b1;
            fail_code = ERR_ORDER;
          end else begin
            res.valid    = 1'b1;
            res.data     = item.data_byte;
            res.offset   = new_pos_r;
            res.done     = last_byte;
            new_pos_nxt  = new_pos_r + 32'd1;
            copy_rem_nxt = copy_rem_r - 32'd1;
            if (copy_rem_r == 32'd1) begin
              seek_now  = 1'b1;
              phase_nxt = PH_CTRL;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // Error result: zero byte at the faulting position, latch and freeze the rest
    if (fail) begin
      res.valid  = 1'b1;
      res.err    = fail_code;
      res.offset = new_pos_r;
      err_nxt    = 1'b1;
    end

    seek_ext    = seek_now ? {{(POS_W-32){seek_sel[31]}}, seek_sel} : '0;
    old_pos_nxt = old_pos_r + seek_ext + {{(POS_W-1){1'b0}}, pos_inc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_pos_r  <= '0;
      old_pos_r  <= '0;
      add_rem_r  <= '0;
      copy_rem_r <= '0;
      seek_r     <= '0;
      phase_r    <= PH_CTRL;
      err_r      <= 1'b0;
    end else if (accept) begin
      new_pos_r  <= new_pos_nxt;
      old_pos_r  <= old_pos_nxt;
      add_rem_r  <= add_rem_nxt;
      copy_rem_r <= copy_rem_nxt;
      seek_r     <= seek_nxt;
      phase_r    <= phase_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

// ----- rtl/binary_delta_patch_apply.sv -----
// Binary delta patch applier. Load the old image first with load words
// (opcode 0), then stream control triples and the decoded diff and extra
// bytes; each diff or extra byte yields one new-image word; out-of-order,
// negative-length or overrunning items yield one error word and lock the
// block until reset. Throughput is one input word per clock while the output
// is taken; a result word passes stage 1, alongside the registered read of
// the old image store, then the output register. The store has no clear
// after reset: an entry read before it was loaded returns garbage.
// Write old_image_size (index 0) and new_image_size (index 1) only while idle.
module binary_delta_patch_apply import bdpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bdpa_in_if.sink               in_ch,
  bdpa_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [OLD_SIZE_W-1:0] old_size_r;
  logic [31:0]           new_size_r;

  item_t             item;
  res_t              res;
  logic              accept;
  logic [OLD_AW-1:0] rd_addr;
  logic [7:0]        ram_q;

  res_t        s1_r;
  logic        s1_adv;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [31:0] out_offset_r;
  logic        out_done_r;
  err_t        out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_size_r <= '0;
      new_size_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OLD_SIZE: old_size_r <= cfg_data[OLD_SIZE_W-1:0];
        CFG_NEW_SIZE: new_size_r <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  assign item.opcode      = opcode_t'(in_ch.opcode);
  assign item.old_address = in_ch.old_address;
  assign item.old_byte    = in_ch.old_byte;
  assign item.add_length  = in_ch.add_length;
  assign item.copy_length = in_ch.copy_length;
  assign item.seek_offset = in_ch.seek_offset;
  assign item.data_byte   = in_ch.data_byte;

  // Stage 1 moves on when the output register is empty or being drained
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_r.valid || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  bdpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (item),
    .old_size (old_size_r),
    .new_size (new_size_r),
    .res      (res),
    .rd_addr  (rd_addr)
  );

  bdpa_old_ram #(
    .DEPTH (OLD_DEPTH),
    .WIDTH (8)
  ) u_old_ram (
    .clk   (clk),
    .we    (accept && item.opcode == OP_LOAD),
    .waddr (OLD_AW'(item.old_address)),
    .wdata (item.old_byte),
    .re    (accept && item.opcode == OP_DIFF),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_r.valid <= accept && res.valid;
    end
    if (accept) begin
      s1_r.use_old <= res.use_old;
      s1_r.data    <= res.data;
      s1_r.offset  <= res.offset;
      s1_r.done    <= res.done;
      s1_r.err     <= res.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_r.valid;
    end
  end

  // Add the old byte, fetched when the stage 1 word was accepted, if use_old is set
  always_ff @(posedge clk) begin
    if (s1_adv && s1_r.valid) begin
      out_byte_r   <= s1_r.data + (s1_r.use_old ? ram_q : 8'd0);
      out_offset_r <= s1_r.offset;
      out_done_r   <= s1_r.done;
      out_err_r    <= s1_r.err;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.new_byte   = out_byte_r;
  assign out_ch.new_offset = out_offset_r;
  assign out_ch.image_done = out_done_r;
  assign out_ch.error_code = out_err_r;

endmodule

// ----- rtl/bdpa_checker.sv -----
module bdpa_checker import bdpa_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  new_byte,
  input logic [31:0] new_offset,
  input logic        image_done,
  input logic [2:0]  error_code
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(new_byte)
      && $stable(new_offset) && $stable(image_done) && $stable(error_code))
    else $error("result word changed while stalled");

  // Error words carry a zero byte and never close the image
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_code != ERR_OK |-> new_byte == 8'd0 && !image_done)
    else $error("error word with payload");

  // Input is never held off while the output is empty
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind binary_delta_patch_apply bdpa_checker u_bdpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .new_byte   (out_ch.new_byte),
  .new_offset (out_ch.new_offset),
  .image_done (out_ch.image_done),
  .error_code (out_ch.error_code)
);
